// File: src/qpmg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpmg_pkg - shared types and codes for the queued pulse mode generator
// Item formats, command codes and default sizes used by every module.
// ----------------------------------------------------------------------------
package qpmg_pkg;

    localparam int CMD_SLOTS_DEF = 8;
    localparam int TICK_BITS_DEF = 16;

    // item opcodes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_CMD  = 1'b1;

    // command types; codes six and seven behave as steady off
    localparam logic [2:0] CMD_OFF       = 3'd0;
    localparam logic [2:0] CMD_ON        = 3'd1;
    localparam logic [2:0] CMD_TIMED_ON  = 3'd2;
    localparam logic [2:0] CMD_TIMED_OFF = 3'd3;
    localparam logic [2:0] CMD_PULSED    = 3'd4;
    localparam logic [2:0] CMD_TOGGLE    = 3'd5;

    typedef struct packed {
        logic        op;
        logic [2:0]  cmd_type;
        logic [15:0] on_ticks;
        logic [15:0] off_ticks;
        logic [15:0] pulse_count;
    } in_item_t;

    typedef struct packed {
        logic       level;
        logic       accepted;
        logic       busy_res;
        logic [3:0] queue_fill;
    } out_item_t;

    // one stored command, 51 bits
    typedef struct packed {
        logic [2:0]  cmd_type;
        logic [15:0] on_ticks;
        logic [15:0] off_ticks;
        logic [15:0] pulse_count;
    } cmd_t;

    // queue requests from the engine
    typedef struct packed {
        logic push;
        logic pop;
    } q_ctl_t;

endpackage

// File: src/qpmg_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpmg_queue - command FIFO
// Circular buffer in a memory with a registered read that always holds
// the entry at the head; a write to the head slot is forwarded.
// ----------------------------------------------------------------------------
module qpmg_queue
    import qpmg_pkg::*;
#(
    parameter int CMD_SLOTS = CMD_SLOTS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  q_ctl_t                             q_ctl,
    input  cmd_t                               wr_data,
    output logic [$clog2(CMD_SLOTS+1)-1:0]     q_count,
    output cmd_t                               head_data
);

    localparam int CNT_W = $clog2(CMD_SLOTS + 1);
    localparam int PTR_W = (CMD_SLOTS > 1) ? $clog2(CMD_SLOTS) : 1;

    cmd_t             mem [CMD_SLOTS];
    cmd_t             head_data_reg;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(CMD_SLOTS - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb begin
        head_next  = q_ctl.pop  ? ptr_inc(head_reg) : head_reg;
        tail_next  = q_ctl.push ? ptr_inc(tail_reg) : tail_reg;
        count_next = count_reg + CNT_W'(q_ctl.push) - CNT_W'(q_ctl.pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // storage and prefetch of the next head entry
    always_ff @(posedge aclk) begin
        if (q_ctl.push) begin
            mem[tail_reg] <= wr_data;
        end
        if (q_ctl.push && (tail_reg == head_next)) begin
            head_data_reg <= wr_data;
        end else begin
            head_data_reg <= mem[head_next];
        end
    end

    assign q_count   = count_reg;
    assign head_data = head_data_reg;

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CMD_SLOTS))
        else $error("queue count above depth");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_ctl.push |-> (count_reg != CNT_W'(CMD_SLOTS)))
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_ctl.pop |-> (count_reg != '0))
        else $error("pop from empty queue");

endmodule

// File: src/qpmg_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpmg_engine - mode state and per-item update
// Applies a tick or a command, then at most one queue pop and a toggle restart.
// Holds the item for extra cycles while queued commands are drained.
// ----------------------------------------------------------------------------
module qpmg_engine
    import qpmg_pkg::*;
#(
    parameter int CMD_SLOTS = CMD_SLOTS_DEF,
    parameter int TICK_BITS = TICK_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               go,
    input  in_item_t                           item,
    input  logic [$clog2(CMD_SLOTS+1)-1:0]     q_count,
    input  cmd_t                               head_data,
    output q_ctl_t                             q_ctl,
    output cmd_t                               wr_data,
    output logic                               done,
    output out_item_t                          result
);

    localparam int CNT_W = $clog2(CMD_SLOTS + 1);
    localparam int EXT_W = (TICK_BITS > 16) ? TICK_BITS : 16;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_HOLD = 2'd1;
    localparam logic [1:0] PH_PON  = 2'd2;
    localparam logic [1:0] PH_POFF = 2'd3;

    typedef struct packed {
        cmd_t                 active;
        cmd_t                 saved;
        logic                 pers;
        logic                 drive;
        logic [TICK_BITS-1:0] ticks;
        logic [15:0]          cycles;
        logic [1:0]           phase;
    } eng_st_t;

    eng_st_t          st_reg, st_next;
    eng_st_t          s1, s2, s3;
    logic             drain_reg, drain_next;
    logic             direct;
    logic             accepted;
    logic             finish;
    logic [CNT_W-1:0] cnt;
    cmd_t             in_cmd;

    // zero lasts one tick, large values saturate
    function automatic logic [TICK_BITS-1:0] delay_len(input logic [15:0] t);
        logic [EXT_W-1:0] ext;
        logic [EXT_W-1:0] lim;
        ext = EXT_W'(t);
        lim = EXT_W'({TICK_BITS{1'b1}});
        if (ext > lim) ext = lim;
        if (ext == '0) ext = EXT_W'(1);
        return TICK_BITS'(ext);
    endfunction

    function automatic eng_st_t restore(input eng_st_t s);
        eng_st_t r;
        r        = s;
        r.drive  = s.pers;
        r.active = s.saved;
        r.phase  = PH_IDLE;
        return r;
    endfunction

    function automatic eng_st_t exec_cmd(input eng_st_t s);
        eng_st_t r;
        r = s;
        case (s.active.cmd_type)
            CMD_ON: begin
                r.drive = 1'b1;
                r.pers  = 1'b1;
            end
            CMD_TIMED_ON: begin
                r.drive = 1'b1;
                r.ticks = delay_len(s.active.on_ticks);
                r.phase = PH_HOLD;
            end
            CMD_TIMED_OFF: begin
                r.drive = 1'b0;
                r.ticks = delay_len(s.active.off_ticks);
                r.phase = PH_HOLD;
            end
            CMD_PULSED: begin
                r.cycles = s.active.pulse_count;
                if (s.active.pulse_count == '0) begin
                    r = restore(r);
                end else begin
                    r.drive = 1'b1;
                    r.ticks = delay_len(s.active.on_ticks);
                    r.phase = PH_PON;
                end
            end
            CMD_TOGGLE: begin
                r.pers  = ~s.pers;
                r.drive = ~s.pers;
                r.ticks = delay_len(s.pers ? s.active.off_ticks : s.active.on_ticks);
                r.phase = PH_HOLD;
            end
            default: begin
                r.drive = 1'b0;
                r.pers  = 1'b0;
            end
        endcase
        return r;
    endfunction

    function automatic eng_st_t take_cmd(input eng_st_t s, input cmd_t c);
        eng_st_t r;
        logic    dup;
        dup = (c.cmd_type inside {CMD_OFF, CMD_ON, CMD_TOGGLE}) &&
              (c.cmd_type == s.active.cmd_type);
        r = s;
        if (!dup) begin
            r.saved  = s.active;
            r.active = c;
            r        = exec_cmd(r);
        end
        return r;
    endfunction

    function automatic eng_st_t finish_phase(input eng_st_t s);
        eng_st_t     r;
        logic [15:0] cyc;
        r   = s;
        cyc = s.cycles - 16'd1;
        case (s.phase)
            PH_HOLD: begin
                if (s.active.cmd_type == CMD_TOGGLE) r.phase = PH_IDLE;
                else r = restore(s);
            end
            PH_PON: begin
                r.drive = 1'b0;
                r.ticks = delay_len(s.active.off_ticks);
                r.phase = PH_POFF;
            end
            PH_POFF: begin
                r.cycles = cyc;
                if (cyc != '0) begin
                    r.drive = 1'b1;
                    r.ticks = delay_len(s.active.on_ticks);
                    r.phase = PH_PON;
                end else begin
                    r = restore(r);
                end
            end
            default: r.phase = PH_IDLE;
        endcase
        return r;
    endfunction

    assign in_cmd = '{cmd_type:    item.cmd_type,
                      on_ticks:    item.on_ticks,
                      off_ticks:   item.off_ticks,
                      pulse_count: item.pulse_count};

    always_comb begin
        s1         = st_reg;
        direct     = 1'b0;
        accepted   = 1'b0;
        q_ctl.push = 1'b0;
        q_ctl.pop  = 1'b0;

        // item action, first cycle only
        if (!drain_reg) begin
            if (item.op == OP_CMD) begin
                if ((st_reg.phase == PH_IDLE) && (q_count == '0)) begin
                    direct   = 1'b1;
                    accepted = 1'b1;
                end else if (q_count < CNT_W'(CMD_SLOTS)) begin
                    q_ctl.push = go;
                    accepted   = 1'b1;
                end
            end else if (st_reg.phase != PH_IDLE) begin
                if (st_reg.ticks != '0) s1.ticks = st_reg.ticks - TICK_BITS'(1);
                if (s1.ticks == '0) s1 = finish_phase(s1);
            end
        end

        // take one command: the incoming one, or the queue head
        s2  = s1;
        cnt = q_count;
        if (s1.phase == PH_IDLE) begin
            if (direct) begin
                s2 = take_cmd(s1, in_cmd);
            end else if (q_count != '0) begin
                q_ctl.pop = go;
                cnt       = q_count - CNT_W'(1);
                s2        = take_cmd(s1, head_data);
            end
        end

        // restart toggling once nothing is waiting
        s3 = s2;
        if ((s2.phase == PH_IDLE) && (cnt == '0) && (s2.active.cmd_type == CMD_TOGGLE)) begin
            s3 = exec_cmd(s2);
        end

        finish     = !((s3.phase == PH_IDLE) && (cnt != '0));
        done       = go && finish;
        st_next    = go ? s3 : st_reg;
        drain_next = go ? !finish : drain_reg;

        result.level      = s3.drive;
        result.accepted   = accepted;
        result.busy_res   = (s3.phase != PH_IDLE);
        result.queue_fill = 4'(cnt + CNT_W'(q_ctl.push));
    end

    assign wr_data = in_cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= '0;
            drain_reg <= 1'b0;
        end else begin
            st_reg    <= st_next;
            drain_reg <= drain_next;
        end
    end

    a_busy_has_ticks: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg.phase != PH_IDLE) |-> (st_reg.ticks != '0))
        else $error("delay running with zero ticks left");

    a_drain_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        drain_reg |-> ((st_reg.phase == PH_IDLE) && (q_count != '0)))
        else $error("drain without idle phase and waiting commands");

endmodule

// File: src/queued_pulse_mode_generator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// queued_pulse_mode_generator_core - queued pulse mode generator, top level
// Timing: the item is held in the input register while the engine works on it,
//   and its result is registered in the result register.
// Throughput: 1 item per cycle while the result side takes each result; a tick
//   that drains several queued commands holds the input, one pop per cycle.
// Reset: aresetn low, synchronous; steady off, level low, queue empty.
// ----------------------------------------------------------------------------
module queued_pulse_mode_generator_core
    import qpmg_pkg::*;
#(
    parameter int CMD_SLOTS = CMD_SLOTS_DEF,
    parameter int TICK_BITS = TICK_BITS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    localparam int CNT_W = $clog2(CMD_SLOTS + 1);

    // Input register: holds the item under work. It frees as soon as the
    // engine finishes the item, so a new item can enter every cycle if not stalled.
    logic      in_valid_reg;
    in_item_t  in_item_reg;

    // Result register: parts the result side from the engine.
    logic      m_valid_reg;
    out_item_t m_item_reg;

    logic             out_free;
    logic             go;
    logic             done;
    out_item_t        result;
    q_ctl_t           q_ctl;
    cmd_t             wr_data;
    cmd_t             head_data;
    logic [CNT_W-1:0] q_count;

    // Advance the engine whenever an item is held and the result slot is
    // empty or being emptied this cycle.
    assign out_free = !m_valid_reg || m_ready;
    assign go       = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // payload: load on accept, hold otherwise
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg <= s_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= done;
        end
    end

    always_ff @(posedge aclk) begin
        if (done) begin
            m_item_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // Command store; written only while a delay runs, read while draining.
    qpmg_queue #(
        .CMD_SLOTS (CMD_SLOTS)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_ctl     (q_ctl),
        .wr_data   (wr_data),
        .q_count   (q_count),
        .head_data (head_data)
    );

    // Mode state, tick countdown and command execution.
    qpmg_engine #(
        .CMD_SLOTS (CMD_SLOTS),
        .TICK_BITS (TICK_BITS)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .go        (go),
        .item      (in_item_reg),
        .q_count   (q_count),
        .head_data (head_data),
        .q_ctl     (q_ctl),
        .wr_data   (wr_data),
        .done      (done),
        .result    (result)
    );

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the queued pulse mode generator core
// Walks a short directed table, then random ticks and commands, through
// both handshakes with random idling. Each result is checked field by field
// against a typed row's value or a cycle-free behavioral model kept here.
// ----------------------------------------------------------------------------
module tb_top;
    import qpmg_pkg::*;

    localparam int GQ_DEPTH      = CMD_SLOTS_DEF;
    localparam int N_RANDOM      = 1326;
    localparam int STALL_LIMIT   = 4000;
    localparam int HOLD_OFF      = 300;
    // spare codes, treated as steady off but never dropped as repeats
    localparam logic [2:0] CMD_SPARE6 = 3'd6;
    localparam logic [2:0] CMD_SPARE7 = 3'd7;
    localparam out_item_t NO_WANT = '0;

    // generator phase in the model
    typedef enum logic [1:0] {
        GP_IDLE,
        GP_HOLD,
        GP_PULSE_ON,
        GP_PULSE_OFF
    } gen_phase_e;

    // one row of the directed table; want is used only when typed is set
    typedef struct packed {
        in_item_t  item;
        logic      typed;
        out_item_t want;
    } dir_row_t;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_item;

    queued_pulse_mode_generator_core #(
        .CMD_SLOTS (CMD_SLOTS_DEF),
        .TICK_BITS (TICK_BITS_DEF)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    // 10 ns clock
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Generator model: command queue, active and saved command, levels
    // ------------------------------------------------------------------
    cmd_t        gq [GQ_DEPTH];
    int unsigned gq_head     = 0;
    int unsigned gq_count    = 0;
    cmd_t        act_cmd     = '0;
    cmd_t        prev_cmd    = '0;
    logic        hold_level  = 1'b0;
    logic        out_level   = 1'b0;
    logic [15:0] ticks_rem   = '0;
    logic [15:0] pulses_rem  = '0;
    gen_phase_e  gen_ph      = GP_IDLE;

    out_item_t   due_results [$];
    int          mism_cnt    = 0;
    bit          no_idle_s   = 1'b0;
    bit          no_idle_m   = 1'b0;

    // start a delay phase; a zero time still lasts one tick
    function automatic void arm_delay(logic [15:0] t, gen_phase_e ph);
        ticks_rem = (t == 16'd0) ? 16'd1 : t;
        gen_ph    = ph;
    endfunction

    // end a timed action: return to the persistent level and prior command
    function automatic void fall_back();
        out_level = hold_level;
        act_cmd   = prev_cmd;
        gen_ph    = GP_IDLE;
    endfunction

    function automatic void apply_active();
        case (act_cmd.cmd_type)
            CMD_ON: begin
                out_level  = 1'b1;
                hold_level = 1'b1;
            end
            CMD_TIMED_ON: begin
                out_level = 1'b1;
                arm_delay(act_cmd.on_ticks, GP_HOLD);
            end
            CMD_TIMED_OFF: begin
                out_level = 1'b0;
                arm_delay(act_cmd.off_ticks, GP_HOLD);
            end
            CMD_PULSED: begin
                pulses_rem = act_cmd.pulse_count;
                if (pulses_rem == 16'd0) begin
                    fall_back();
                end else begin
                    out_level = 1'b1;
                    arm_delay(act_cmd.on_ticks, GP_PULSE_ON);
                end
            end
            CMD_TOGGLE: begin
                hold_level = ~hold_level;
                out_level  = hold_level;
                arm_delay(hold_level ? act_cmd.on_ticks : act_cmd.off_ticks, GP_HOLD);
            end
            default: begin
                out_level  = 1'b0;
                hold_level = 1'b0;
            end
        endcase
    endfunction

    // advance the model by one item and return the result it causes
    function automatic out_item_t model_item(in_item_t it);
        cmd_t      c;
        logic      took;
        int        g;
        out_item_t r;
        took = 1'b0;
        if (it.op == OP_CMD) begin
            if (gq_count < GQ_DEPTH) begin
                gq[(gq_head + gq_count) % GQ_DEPTH] =
                    cmd_t'{it.cmd_type, it.on_ticks, it.off_ticks, it.pulse_count};
                gq_count++;
                took = 1'b1;
            end
        end else if (gen_ph != GP_IDLE) begin
            if (ticks_rem != 16'd0) ticks_rem--;
            if (ticks_rem == 16'd0) begin
                case (gen_ph)
                    GP_HOLD: begin
                        // a toggle half period ends into idle; timed actions restore
                        if (act_cmd.cmd_type == CMD_TOGGLE) gen_ph = GP_IDLE;
                        else fall_back();
                    end
                    GP_PULSE_ON: begin
                        out_level = 1'b0;
                        arm_delay(act_cmd.off_ticks, GP_PULSE_OFF);
                    end
                    default: begin
                        pulses_rem--;
                        if (pulses_rem != 16'd0) begin
                            out_level = 1'b1;
                            arm_delay(act_cmd.on_ticks, GP_PULSE_ON);
                        end else begin
                            fall_back();
                        end
                    end
                endcase
            end
        end
        // drain the queue while no delay runs, all within this item
        for (g = 0; g < 2 * GQ_DEPTH + 4 && gen_ph == GP_IDLE; g++) begin
            if (gq_count > 0) begin
                c       = gq[gq_head];
                gq_head = (gq_head + 1) % GQ_DEPTH;
                gq_count--;
                // drop a steady or toggle command that repeats the active type
                if (!((c.cmd_type == CMD_OFF || c.cmd_type == CMD_ON ||
                       c.cmd_type == CMD_TOGGLE) && c.cmd_type == act_cmd.cmd_type)) begin
                    prev_cmd = act_cmd;
                    act_cmd  = c;
                    apply_active();
                end
            end else if (act_cmd.cmd_type == CMD_TOGGLE) begin
                apply_active();
            end else begin
                break;
            end
        end
        r.level      = out_level;
        r.accepted   = took;
        r.busy_res   = (gen_ph != GP_IDLE);
        r.queue_fill = gq_count[3:0];
        return r;
    endfunction

    function automatic in_item_t cmd_item(logic [2:0] t, logic [15:0] on_t,
                                          logic [15:0] off_t, logic [15:0] cnt);
        return in_item_t'{OP_CMD, t, on_t, off_t, cnt};
    endfunction

    function automatic in_item_t tick_item();
        return in_item_t'{OP_TICK, CMD_OFF, 16'd0, 16'd0, 16'd0};
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("%0t ns  %s: got %0h, want %0h", $time, what, got, want);
        mism_cnt++;
    endtask

    // Offer one item, wait for the handshake, then log its expected result.
    // Valid stays high across back-to-back items and drops only during a gap.
    task automatic send_item(in_item_t it, logic typed, out_item_t want);
        int        gap;
        out_item_t pred;
        if ($urandom_range(0, 49) == 0) no_idle_s = !no_idle_s;
        gap = no_idle_s ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        pred = model_item(it);
        due_results.push_back(typed ? want : pred);
    endtask

    // ------------------------------------------------------------------
    // Sender: reset, directed table, random items, drain and verdict
    // ------------------------------------------------------------------
    initial begin
        dir_row_t dir_rows [24];
        in_item_t it;
        int       n;
        int       pick;
        int       burst_left;
        burst_left = 0;
        s_valid <= 1'b0;
        s_item  <= '0;
        aresetn <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        dir_rows = '{
            // tick while idle: nothing moves
            '{tick_item(), 1'b1, out_item_t'{1'b0, 1'b0, 1'b0, 4'd0}},
            // steady off repeats the reset mode: drop it
            '{cmd_item(CMD_OFF, 16'd0, 16'd0, 16'd0), 1'b1,
              out_item_t'{1'b0, 1'b1, 1'b0, 4'd0}},
            // steady on with every time field at its maximum
            '{cmd_item(CMD_ON, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b1,
              out_item_t'{1'b1, 1'b1, 1'b0, 4'd0}},
            '{cmd_item(CMD_ON, 16'd0, 16'd0, 16'd0), 1'b1,
              out_item_t'{1'b1, 1'b1, 1'b0, 4'd0}},
            // timed off with zero time: hold low for one tick, then restore
            '{cmd_item(CMD_TIMED_OFF, 16'hFFFF, 16'd0, 16'd0), 1'b1,
              out_item_t'{1'b0, 1'b1, 1'b1, 4'd0}},
            '{tick_item(), 1'b1, out_item_t'{1'b1, 1'b0, 1'b0, 4'd0}},
            // pulsed with zero count restores at once
            '{cmd_item(CMD_PULSED, 16'd3, 16'd3, 16'd0), 1'b0, NO_WANT},
            '{cmd_item(CMD_PULSED, 16'd1, 16'd0, 16'd2), 1'b0, NO_WANT},
            '{tick_item(), 1'b0, NO_WANT},
            '{tick_item(), 1'b0, NO_WANT},
            '{tick_item(), 1'b0, NO_WANT},
            '{tick_item(), 1'b0, NO_WANT},
            // spare codes act as steady off and are never dropped
            '{cmd_item(CMD_SPARE6, 16'h8000, 16'h8000, 16'h8000), 1'b0, NO_WANT},
            '{cmd_item(CMD_SPARE7, 16'd0, 16'd0, 16'd0), 1'b0, NO_WANT},
            '{cmd_item(CMD_TOGGLE, 16'd3, 16'd2, 16'hFFFF), 1'b0, NO_WANT},
            // fill the queue while the toggle half period runs
            '{cmd_item(CMD_TIMED_ON, 16'd0, 16'hFFFF, 16'hFFFF), 1'b0, NO_WANT},
            '{cmd_item(CMD_TIMED_OFF, 16'hFFFF, 16'd1, 16'hFFFF), 1'b0, NO_WANT},
            '{cmd_item(CMD_PULSED, 16'd1, 16'd1, 16'd1), 1'b0, NO_WANT},
            '{cmd_item(CMD_TOGGLE, 16'd0, 16'd0, 16'd0), 1'b0, NO_WANT},
            '{cmd_item(CMD_ON, 16'd0, 16'd0, 16'd0), 1'b0, NO_WANT},
            '{cmd_item(CMD_OFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b0, NO_WANT},
            '{cmd_item(CMD_SPARE6, 16'd0, 16'd0, 16'd0), 1'b0, NO_WANT},
            '{cmd_item(CMD_TIMED_ON, 16'd2, 16'hFFFF, 16'hFFFF), 1'b0, NO_WANT},
            // full queue: reject
            '{cmd_item(CMD_ON, 16'd0, 16'd0, 16'd0), 1'b1,
              out_item_t'{1'b1, 1'b0, 1'b1, 4'd8}}
        };
        foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

        // Random part. Keep used times short so actions finish; fill the
        // fields a mode ignores with full-range values so every bit moves.
        for (n = 0; n < N_RANDOM; n++) begin
            it.op          = OP_TICK;
            it.cmd_type    = 3'($urandom);
            it.on_ticks    = 16'($urandom);
            it.off_ticks   = 16'($urandom);
            it.pulse_count = 16'($urandom);
            if (burst_left == 0 && $urandom_range(0, 39) == 0)
                burst_left = $urandom_range(6, 12);
            if (burst_left > 0 || $urandom_range(0, 99) < 42) begin
                if (burst_left > 0) burst_left--;
                it.op = OP_CMD;
                pick  = $urandom_range(0, 15);
                case (pick)
                    0, 1:     it.cmd_type = CMD_OFF;
                    2, 3:     it.cmd_type = CMD_ON;
                    4, 5:     it.cmd_type = CMD_TIMED_ON;
                    6, 7:     it.cmd_type = CMD_TIMED_OFF;
                    8, 9, 10: it.cmd_type = CMD_PULSED;
                    14:       it.cmd_type = CMD_SPARE6;
                    15:       it.cmd_type = CMD_SPARE7;
                    default:  it.cmd_type = CMD_TOGGLE;
                endcase
                case (it.cmd_type)
                    CMD_TIMED_ON:  it.on_ticks  = 16'($urandom_range(0, 4));
                    CMD_TIMED_OFF: it.off_ticks = 16'($urandom_range(0, 4));
                    CMD_PULSED: begin
                        it.on_ticks    = 16'($urandom_range(0, 4));
                        it.off_ticks   = 16'($urandom_range(0, 4));
                        it.pulse_count = 16'($urandom_range(0, 3));
                    end
                    CMD_TOGGLE: begin
                        it.on_ticks  = 16'($urandom_range(0, 4));
                        it.off_ticks = 16'($urandom_range(0, 4));
                    end
                    default: ;
                endcase
            end
            send_item(it, 1'b0, NO_WANT);
        end
        s_valid <= 1'b0;

        // drain, then allow the worst-case queue walk for stray items
        while (due_results.size() != 0) @(posedge aclk);
        repeat (GQ_DEPTH + 8) @(posedge aclk);
        if (mism_cnt == 0) begin
            $display("queued_pulse_mode_generator_core: match");
        end else begin
            $display("queued_pulse_mode_generator_core: mismatch");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random ready gaps, plus long hold-offs to back up the block
    // ------------------------------------------------------------------
    initial begin
        int gap;
        int taken;
        taken = 0;
        m_ready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if ($urandom_range(0, 49) == 0) no_idle_m = !no_idle_m;
            gap = no_idle_m ? 0 : $urandom_range(0, 17);
            // hold off long enough for the sender to stall on a full block
            if (taken == 250 || taken == 900) gap = HOLD_OFF;
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            taken++;
        end
    end

    // Check each result item against the oldest expectation.
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (due_results.size() == 0) begin
                report_mismatch("result with nothing expected", 16'(m_item), 16'd0);
            end else begin
                want = due_results.pop_front();
                if (m_item.level !== want.level)
                    report_mismatch("level", 16'(m_item.level), 16'(want.level));
                if (m_item.accepted !== want.accepted)
                    report_mismatch("accepted", 16'(m_item.accepted), 16'(want.accepted));
                if (m_item.busy_res !== want.busy_res)
                    report_mismatch("busy_res", 16'(m_item.busy_res), 16'(want.busy_res));
                if (m_item.queue_fill !== want.queue_fill)
                    report_mismatch("queue_fill", 16'(m_item.queue_fill),
                                    16'(want.queue_fill));
            end
        end
    end

    // Watchdog: end the run when no handshake happens for too long.
    initial begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("queued_pulse_mode_generator_core: mismatch");
        $finish;
    end

endmodule

// File: queued_pulse_mode_generator_core.f
src/qpmg_pkg.sv
src/qpmg_queue.sv
src/qpmg_engine.sv
src/queued_pulse_mode_generator_core.sv
verif/tb_top.sv
